// ===== design/ndtlv_pkg.sv =====
// Shared types, constants and the helper function of the NDEF TLV header decoder.
`default_nettype none
package ndtlv_pkg;

	// Size of one tag data block in bytes; a power of two.
	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int POS_W = $clog2(BLOCK_BYTES);

	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int START_W = 5;
	localparam int BLOCKS_W = 13;
	localparam int TOTAL_W = LEN_W + 1;

	localparam logic [BYTE_W-1:0] TLV_NULL = 8'h00;
	localparam logic [BYTE_W-1:0] TLV_NDEF = 8'h03;
	localparam logic [BYTE_W-1:0] LEN_LONG = 8'hFF;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);

	typedef enum logic [1:0] {
		STATUS_DECODED  = 2'd0,
		STATUS_UNKNOWN  = 2'd1,
		STATUS_NO_TLV   = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_SEARCH = 6'b000010,
		PH_LEN    = 6'b000100,
		PH_LENHI  = 6'b001000,
		PH_LENLO  = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic                 emit;
		status_t              status;
		logic [LEN_W-1:0]     len;
		logic [START_W-1:0]   start;
		logic [BLOCKS_W-1:0]  blocks;
	} result_t;

	// Blocks that hold the TLV header, the message and the terminator TLV.
	function automatic logic [BLOCKS_W-1:0] blocks_for(input logic [LEN_W-1:0] len);
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] rounded;
		total = {1'b0, len} + ((len < TOTAL_W'(LEN_LONG)) ? TOTAL_W'(3) : TOTAL_W'(5));
		rounded = (total + TOTAL_W'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
		return rounded[BLOCKS_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/ndtlv_core.sv =====
// Header parse state machine: state registers and the per-byte decision logic.
`default_nettype none
module ndtlv_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [ndtlv_pkg::BYTE_W-1:0]  byte_in,
	input  wire logic                          restart,
	output ndtlv_pkg::result_t                 result
);

	ndtlv_pkg::phase_t                 phase_q, phase_d, phase_eff;
	logic [ndtlv_pkg::POS_W-1:0]       pos_q, pos_d, pos_eff;
	logic [ndtlv_pkg::POS_W-1:0]       type_q, type_d, type_eff;
	logic [ndtlv_pkg::BYTE_W-1:0]      hi_q, hi_d, hi_eff;
	logic [ndtlv_pkg::LEN_W-1:0]       ok_len;
	logic [ndtlv_pkg::START_W-1:0]     ok_start;

	always_comb begin
		// A block start discards any header in progress.
		phase_eff = restart ? ndtlv_pkg::PH_SEARCH : phase_q;
		pos_eff   = restart ? '0 : pos_q;
		type_eff  = restart ? '0 : type_q;
		hi_eff    = restart ? '0 : hi_q;

		phase_d = phase_eff;
		pos_d   = pos_eff;
		type_d  = type_eff;
		hi_d    = hi_eff;

		result.emit   = 1'b0;
		result.status = ndtlv_pkg::STATUS_DECODED;
		ok_len        = '0;
		ok_start      = '0;

		case (phase_eff)
			ndtlv_pkg::PH_SEARCH: begin
				if (byte_in == ndtlv_pkg::TLV_NDEF) begin
					type_d  = pos_eff;
					phase_d = ndtlv_pkg::PH_LEN;
				end else if (byte_in != ndtlv_pkg::TLV_NULL) begin
					result.emit   = 1'b1;
					result.status = ndtlv_pkg::STATUS_UNKNOWN;
				end else if (pos_eff == ndtlv_pkg::LAST_POS) begin
					result.emit   = 1'b1;
					result.status = ndtlv_pkg::STATUS_NO_TLV;
				end else begin
					pos_d = pos_eff + 1'b1;
				end
			end
			ndtlv_pkg::PH_LEN: begin
				if (byte_in == ndtlv_pkg::LEN_LONG) begin
					phase_d = ndtlv_pkg::PH_LENHI;
				end else begin
					result.emit = 1'b1;
					ok_len      = {{(ndtlv_pkg::LEN_W-ndtlv_pkg::BYTE_W){1'b0}}, byte_in};
					ok_start    = ndtlv_pkg::START_W'(type_eff) + ndtlv_pkg::START_W'(2);
				end
			end
			ndtlv_pkg::PH_LENHI: begin
				hi_d    = byte_in;
				phase_d = ndtlv_pkg::PH_LENLO;
			end
			ndtlv_pkg::PH_LENLO: begin
				result.emit = 1'b1;
				ok_len      = {hi_eff, byte_in};
				ok_start    = ndtlv_pkg::START_W'(type_eff) + ndtlv_pkg::START_W'(4);
			end
			default: begin
				phase_d = phase_eff;
			end
		endcase

		if (result.emit) begin
			phase_d = ndtlv_pkg::PH_DONE;
		end

		// Error results carry zeros in every numeric field.
		if (result.status == ndtlv_pkg::STATUS_DECODED) begin
			result.len    = ok_len;
			result.start  = ok_start;
			result.blocks = ndtlv_pkg::blocks_for(ok_len);
		end else begin
			result.len    = '0;
			result.start  = '0;
			result.blocks = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ndtlv_pkg::PH_IDLE;
			pos_q   <= '0;
			type_q  <= '0;
			hi_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			type_q  <= type_d;
			hi_q    <= hi_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/ndef_tlv_header_decoder_unit.sv =====
// Top level of the NDEF TLV header decoder: input register, parser and result register.
`default_nettype none
// The decoder takes the bytes of the first NDEF data block, one request per byte, and
// returns at most one result request per block: a status, the NDEF message length, the
// byte offset where the message starts and the number of 16-byte blocks needed for the
// TLV header, the message and the terminator. A request with block_start high restarts
// the parser at that byte; bytes before the first block start and bytes after the
// result are dropped without a result. Null TLVs are skipped, the first 0x03 type byte
// within the block opens the NDEF TLV, and any other type byte ends the search with an
// unknown-type status. A block of nulls gives the no-TLV status at its last byte. The
// length is one byte, or 0xFF followed by a big-endian 16-bit value. A byte is taken
// every cycle unless a result stall holds it: it is held in the input register, is
// decided there by the parser, and its result, if any, is written into the output
// register when the byte moves on. Input ready drops only when a byte that produces a
// result meets an output register that still holds an untaken result; bytes that
// produce no result keep flowing during such a stall.
module ndef_tlv_header_decoder_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [ndtlv_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                            block_start,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [1:0]                      status,
	output      logic [ndtlv_pkg::LEN_W-1:0]     message_length,
	output      logic [ndtlv_pkg::START_W-1:0]   start_index,
	output      logic [ndtlv_pkg::BLOCKS_W-1:0]  blocks_needed
);

	logic                             valid_s1;
	logic [ndtlv_pkg::BYTE_W-1:0]     byte_s1;
	logic                             start_s1;
	logic                             advance;
	ndtlv_pkg::result_t               result;

	logic                             out_valid_q;
	ndtlv_pkg::status_t               status_q;
	logic [ndtlv_pkg::LEN_W-1:0]      len_q;
	logic [ndtlv_pkg::START_W-1:0]    start_q;
	logic [ndtlv_pkg::BLOCKS_W-1:0]   blocks_q;

	ndtlv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.restart (start_s1),
		.result  (result)
	);

	// The held byte moves on unless its result would overwrite an untaken one.
	assign advance  = valid_s1 && (!result.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			start_s1 <= block_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			status_q <= result.status;
			len_q    <= result.len;
			start_q  <= result.start;
			blocks_q <= result.blocks;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign message_length = len_q;
	assign start_index    = start_q;
	assign blocks_needed  = blocks_q;

endmodule
`default_nettype wire
